@@ design/flvscan_pkg.sv @@
// ----------------------------------------------------------------------------
// flvscan_pkg
// Types, codes and constants shared by the FLV video tag NALU type scanner.
// ----------------------------------------------------------------------------
package flvscan_pkg;

    localparam int TAG_INDEX_BITS_DEF = 16;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_HDR_LEAD  = 4'd0,
        PH_HDR_LEN   = 4'd1,
        PH_SKIP      = 4'd2,
        PH_TAG_TYPE  = 4'd3,
        PH_TAG_SIZE  = 4'd4,
        PH_VHDR_REST = 4'd5,
        PH_FRAME     = 4'd6,
        PH_PACKET    = 4'd7,
        PH_CTIME     = 4'd8,
        PH_NLEN      = 4'd9,
        PH_NHDR      = 4'd10,
        PH_NBODY     = 4'd11
    } phase_t;

    // Result kinds.
    localparam logic [1:0] KIND_NALU    = 2'd0;
    localparam logic [1:0] KIND_SEQ_HDR = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_HDR_LEN    = 3'd1;
    localparam logic [2:0] ERR_PKT_TYPE   = 3'd2;
    localparam logic [2:0] ERR_CTIME      = 3'd3;
    localparam logic [2:0] ERR_NALU_TYPE  = 3'd4;
    localparam logic [2:0] ERR_NALU_LEN   = 3'd5;

    // FLV tag types.
    localparam logic [7:0] TAG_AUDIO  = 8'd8;
    localparam logic [7:0] TAG_VIDEO  = 8'd9;
    localparam logic [7:0] TAG_SCRIPT = 8'd18;

    // AVC packet types.
    localparam logic [7:0] AVC_SEQ_HDR = 8'd0;
    localparam logic [7:0] AVC_NALU    = 8'd1;

    // Accepted NALU types: non-IDR slice, and IDR slice through access unit delimiter.
    localparam logic [4:0] NALU_NON_IDR = 5'd1;
    localparam logic [4:0] NALU_IDR     = 5'd5;
    localparam logic [4:0] NALU_AUD     = 5'd9;

    // Field lengths and skip counts in bytes.
    localparam logic [2:0]  HDR_LEAD_BYTES   = 3'd5;
    localparam logic [2:0]  WORD_BYTES       = 3'd4;
    localparam logic [2:0]  SIZE_BYTES       = 3'd3;
    localparam logic [31:0] FLV_HDR_LEN      = 32'd9;
    localparam logic [24:0] PREV_SIZE_BYTES  = 25'd4;
    localparam logic [24:0] VHDR_REST_BYTES  = 25'd7;
    localparam logic [24:0] TAG_TAIL_BYTES   = 25'd11;
    localparam logic [24:0] SEQ_TAIL_BYTES   = 25'd2;
    localparam logic [24:0] AVC_PREFIX_BYTES = 25'd5;
    localparam logic [32:0] NLEN_WORD_BYTES  = 33'd4;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tag_index;
        logic [4:0]  nalu_type;
        logic        last_in_tag;
        logic [2:0]  error_code;
    } out_item_t;

    typedef struct packed {
        logic      has_result;
        logic      halted;
        out_item_t result;
    } parse_status_t;

endpackage

@@ design/flvscan_stream_if.sv @@
// ----------------------------------------------------------------------------
// flvscan_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface flvscan_stream_if #(parameter type data_t = logic);

    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ design/flvscan_in_reg.sv @@
// ----------------------------------------------------------------------------
// flvscan_in_reg
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module flvscan_in_reg
    import flvscan_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    flvscan_stream_if.sink   byte_stream,
    input  logic             take,
    output logic             item_valid,
    output in_item_t         item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign byte_stream.ready = !valid_reg || take;
    assign accept            = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= byte_stream.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/flvscan_parser.sv @@
// ----------------------------------------------------------------------------
// flvscan_parser
// Parser state and the per-byte decode that forms the next state and result.
// ----------------------------------------------------------------------------
module flvscan_parser
    import flvscan_pkg::*;
#(
    parameter int TAG_INDEX_BITS = TAG_INDEX_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  in_item_t      item,
    output parse_status_t status
);

    phase_t                    phase_reg, phase_next;
    logic [2:0]                fc_reg, fc_next;
    logic [31:0]               asm_reg, asm_next;
    logic [23:0]               size_reg, size_next;
    logic [24:0]               skip_reg, skip_next;
    logic [24:0]               used_reg, used_next;
    logic [TAG_INDEX_BITS-1:0] vt_reg, vt_next;
    logic                      halted_reg, halted_next;

    // State as seen by this byte: a first mark restarts from the reset state.
    phase_t                    a_phase;
    logic [2:0]                a_fc;
    logic [31:0]               a_asm;
    logic [23:0]               a_size;
    logic [24:0]               a_skip;
    logic [24:0]               a_used;
    logic [TAG_INDEX_BITS-1:0] a_vt;
    logic                      a_halted;

    logic [7:0]  b;
    logic [31:0] asm_shift;
    logic [2:0]  fc_inc;
    logic [24:0] skip_dec;
    logic [32:0] nlen_total;
    logic        nlen_bad;
    logic        used_end;
    logic        prefix_end;
    logic [23:0] size_shift;
    logic [4:0]  ntype;
    logic        ntype_ok;
    logic        tag_known;
    logic [31:0] vt_wide;

    always_comb
    begin
        b          = item.byte_in;
        a_phase    = item.first ? PH_HDR_LEAD : phase_reg;
        a_fc       = item.first ? 3'd0 : fc_reg;
        a_asm      = item.first ? 32'd0 : asm_reg;
        a_size     = item.first ? 24'd0 : size_reg;
        a_skip     = item.first ? 25'd0 : skip_reg;
        a_used     = item.first ? 25'd0 : used_reg;
        a_vt       = item.first ? '0 : vt_reg;
        a_halted   = item.first ? 1'b0 : halted_reg;

        asm_shift  = {a_asm[23:0], b};
        size_shift = {a_size[15:0], b};
        fc_inc     = a_fc + 3'd1;
        skip_dec   = (a_skip != 25'd0) ? a_skip - 25'd1 : 25'd0;
        nlen_total = {8'd0, a_used} + NLEN_WORD_BYTES + {1'b0, asm_shift};
        nlen_bad   = (asm_shift == 32'd0) || (nlen_total > {9'd0, a_size});
        used_end   = (a_used == {1'b0, a_size});
        prefix_end = (AVC_PREFIX_BYTES == {1'b0, a_size});
        ntype      = b[4:0];
        ntype_ok   = ntype inside {NALU_NON_IDR, [NALU_IDR:NALU_AUD]};
        tag_known  = b inside {TAG_AUDIO, TAG_VIDEO, TAG_SCRIPT};
        vt_wide    = 32'(a_vt);
    end

    // Next state.
    always_comb
    begin
        phase_next  = a_phase;
        fc_next     = a_fc;
        asm_next    = a_asm;
        size_next   = a_size;
        skip_next   = a_skip;
        used_next   = a_used;
        vt_next     = a_vt;
        halted_next = a_halted;

        if (!a_halted)
        begin
            case (a_phase)
                PH_HDR_LEAD:
                begin
                    fc_next = fc_inc;
                    if (fc_inc >= HDR_LEAD_BYTES)
                    begin
                        fc_next    = 3'd0;
                        asm_next   = 32'd0;
                        phase_next = PH_HDR_LEN;
                    end
                end
                PH_HDR_LEN:
                begin
                    asm_next = asm_shift;
                    fc_next  = fc_inc;
                    if (fc_inc >= WORD_BYTES)
                    begin
                        fc_next = 3'd0;
                        if (asm_shift != FLV_HDR_LEN)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            skip_next  = PREV_SIZE_BYTES;
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP, PH_VHDR_REST:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 25'd0)
                    begin
                        phase_next = (a_phase == PH_SKIP) ? PH_TAG_TYPE : PH_FRAME;
                    end
                end
                PH_TAG_TYPE:
                begin
                    if (!tag_known)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        asm_next   = {24'd0, b};
                        size_next  = 24'd0;
                        fc_next    = 3'd0;
                        phase_next = PH_TAG_SIZE;
                    end
                end
                PH_TAG_SIZE:
                begin
                    size_next = size_shift;
                    fc_next   = fc_inc;
                    if (fc_inc >= SIZE_BYTES)
                    begin
                        fc_next = 3'd0;
                        if (a_asm != {24'd0, TAG_VIDEO})
                        begin
                            skip_next  = {1'b0, size_shift} + TAG_TAIL_BYTES;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            skip_next  = VHDR_REST_BYTES;
                            phase_next = PH_VHDR_REST;
                        end
                    end
                end
                PH_FRAME:
                begin
                    phase_next = PH_PACKET;
                end
                PH_PACKET:
                begin
                    if (b == AVC_SEQ_HDR)
                    begin
                        vt_next    = a_vt + TAG_INDEX_BITS'(1);
                        skip_next  = {1'b0, a_size} + SEQ_TAIL_BYTES;
                        phase_next = PH_SKIP;
                    end
                    else if (b != AVC_NALU)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        fc_next    = 3'd0;
                        asm_next   = 32'd0;
                        phase_next = PH_CTIME;
                    end
                end
                PH_CTIME:
                begin
                    asm_next = asm_shift;
                    fc_next  = fc_inc;
                    if (fc_inc >= SIZE_BYTES)
                    begin
                        if (asm_shift[23:0] != 24'd0)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            used_next = AVC_PREFIX_BYTES;
                            if (prefix_end)
                            begin
                                vt_next    = a_vt + TAG_INDEX_BITS'(1);
                                skip_next  = PREV_SIZE_BYTES;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                fc_next    = 3'd0;
                                asm_next   = 32'd0;
                                phase_next = PH_NLEN;
                            end
                        end
                    end
                end
                PH_NLEN:
                begin
                    asm_next = asm_shift;
                    fc_next  = fc_inc;
                    if (fc_inc >= WORD_BYTES)
                    begin
                        fc_next = 3'd0;
                        if (nlen_bad)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            used_next  = nlen_total[24:0];
                            skip_next  = asm_shift[24:0] - 25'd1;
                            phase_next = PH_NHDR;
                        end
                    end
                end
                PH_NHDR, PH_NBODY:
                begin
                    if ((a_phase == PH_NHDR) && !ntype_ok)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        // The header byte is the first of the NALU; the body
                        // counts the rest down.
                        if (a_phase == PH_NBODY)
                        begin
                            skip_next = skip_dec;
                        end
                        if (((a_phase == PH_NHDR) ? a_skip : skip_dec) != 25'd0)
                        begin
                            phase_next = PH_NBODY;
                        end
                        else if (used_end)
                        begin
                            vt_next    = a_vt + TAG_INDEX_BITS'(1);
                            skip_next  = PREV_SIZE_BYTES;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            fc_next    = 3'd0;
                            asm_next   = 32'd0;
                            phase_next = PH_NLEN;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HDR_LEAD;
                end
            endcase
        end
    end

    // Result for this byte.
    always_comb
    begin
        status.has_result         = 1'b0;
        status.halted             = halted_reg;
        status.result.kind        = KIND_NALU;
        status.result.tag_index   = vt_wide[15:0];
        status.result.nalu_type   = 5'd0;
        status.result.last_in_tag = 1'b0;
        status.result.error_code  = ERR_NONE;

        if (!a_halted)
        begin
            case (a_phase)
                PH_HDR_LEN:
                begin
                    if ((fc_inc >= WORD_BYTES) && (asm_shift != FLV_HDR_LEN))
                    begin
                        status.has_result        = 1'b1;
                        status.result.kind       = KIND_ERROR;
                        status.result.error_code = ERR_HDR_LEN;
                    end
                end
                PH_TAG_TYPE:
                begin
                    if (!tag_known)
                    begin
                        status.has_result  = 1'b1;
                        status.result.kind = KIND_END;
                    end
                end
                PH_PACKET:
                begin
                    if (b == AVC_SEQ_HDR)
                    begin
                        status.has_result  = 1'b1;
                        status.result.kind = KIND_SEQ_HDR;
                    end
                    else if (b != AVC_NALU)
                    begin
                        status.has_result        = 1'b1;
                        status.result.kind       = KIND_ERROR;
                        status.result.error_code = ERR_PKT_TYPE;
                    end
                end
                PH_CTIME:
                begin
                    if ((fc_inc >= SIZE_BYTES) && (asm_shift[23:0] != 24'd0))
                    begin
                        status.has_result        = 1'b1;
                        status.result.kind       = KIND_ERROR;
                        status.result.error_code = ERR_CTIME;
                    end
                end
                PH_NLEN:
                begin
                    if ((fc_inc >= WORD_BYTES) && nlen_bad)
                    begin
                        status.has_result        = 1'b1;
                        status.result.kind       = KIND_ERROR;
                        status.result.error_code = ERR_NALU_LEN;
                    end
                end
                PH_NHDR:
                begin
                    status.has_result       = 1'b1;
                    status.result.nalu_type = ntype;
                    if (!ntype_ok)
                    begin
                        status.result.kind       = KIND_ERROR;
                        status.result.error_code = ERR_NALU_TYPE;
                    end
                    else
                    begin
                        status.result.kind        = KIND_NALU;
                        status.result.last_in_tag = used_end;
                    end
                end
                default:
                begin
                    status.has_result = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR_LEAD;
            fc_reg     <= 3'd0;
            asm_reg    <= 32'd0;
            size_reg   <= 24'd0;
            skip_reg   <= 25'd0;
            used_reg   <= 25'd0;
            vt_reg     <= '0;
            halted_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            fc_reg     <= fc_next;
            asm_reg    <= asm_next;
            size_reg   <= size_next;
            skip_reg   <= skip_next;
            used_reg   <= used_next;
            vt_reg     <= vt_next;
            halted_reg <= halted_next;
        end
    end

endmodule

@@ design/flvscan_out_reg.sv @@
// ----------------------------------------------------------------------------
// flvscan_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module flvscan_out_reg
    import flvscan_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  out_item_t         item,
    flvscan_stream_if.source  result_stream,
    output logic              space
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign space = !valid_reg || result_stream.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_stream.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign result_stream.valid = valid_reg;
    assign result_stream.data  = item_reg;

endmodule

@@ design/flv_avc_nalu_type_scanner.sv @@
// ----------------------------------------------------------------------------
// flv_avc_nalu_type_scanner
// Byte-stream FLV parser that reports AVC NALU types found in video tags.
// ----------------------------------------------------------------------------
// Usage:
//   byte_stream carries one file byte per transfer, with a first flag that
//   marks byte 0 of a file and restarts the parser, clearing any halt.
//   result_stream carries at most one result per byte: a NALU type with its
//   video tag index and a last-in-tag flag, a sequence header event, an end
//   of stream on an unknown tag type, or an error code.
//   A byte sits in the input register while the decode logic forms its
//   result, and the clock edge on which the parser consumes the byte
//   writes the result register, which drives result_stream. Throughput
//   is one byte per cycle while no result waits on a stalled receiver,
//   set by the parser updating its state once per byte.
//   After an error or an end of stream the parser drops bytes silently until
//   a byte with first set arrives.
//   Reset puts the parser at the start of a file with the tag counter at
//   zero; there is no clearing pass, so bytes are taken right after reset.
//   When the receiver stalls, the result waits in the result register, one
//   more byte waits in the input register, and bytes that produce no result
//   keep flowing through the parser.
// ----------------------------------------------------------------------------
module flv_avc_nalu_type_scanner
    import flvscan_pkg::*;
#(
    parameter int TAG_INDEX_BITS = TAG_INDEX_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    flvscan_stream_if.sink   byte_stream,
    flvscan_stream_if.source result_stream
);

    logic          item_valid;
    in_item_t      item;
    logic          advance;
    logic          load;
    logic          space;
    parse_status_t status;

    // The byte in the input register moves through the parser when its
    // result, if it has one, can be written to the result register.
    assign advance = item_valid && (!status.has_result || space);
    assign load    = advance && status.has_result;

    flvscan_in_reg u_in_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .take        (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    flvscan_parser #(
        .TAG_INDEX_BITS (TAG_INDEX_BITS)
    ) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .status  (status)
    );

    flvscan_out_reg u_out_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .item          (status.result),
        .result_stream (result_stream),
        .space         (space)
    );

    // A held byte stays held until the parser consumes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !advance) |=> item_valid)
        else $error("input register lost a byte that was not consumed");

    // Error results always carry an error code, other results never do.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_stream.valid |->
            ((result_stream.data.kind == KIND_ERROR) ==
             (result_stream.data.error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    // An error or end of stream halts the parser.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && ((status.result.kind == KIND_ERROR) ||
                  (status.result.kind == KIND_END))) |=> status.halted)
        else $error("parser did not halt after error or end of stream");

    // A halted parser produces no result unless the byte restarts it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && status.halted && !item.first) |-> !status.has_result)
        else $error("halted parser produced a result");

endmodule
